// ----- rtl/u8d_pkg.sv -----
// shared types and constants of the chunked utf-8 string deframer
`default_nettype none

package u8d_pkg;

    // parser phases
    typedef enum logic [2:0] {
        PH_PREFIX = 3'd0,
        PH_LEN2   = 3'd1,
        PH_WORDHI = 3'd2,
        PH_WORDLO = 3'd3,
        PH_LEAD   = 3'd4,
        PH_CONT1  = 3'd5,
        PH_CONTN  = 3'd6
    } t_phase;

    // prefix byte codes
    localparam logic [7:0] SHORT_LEN_MAX = 8'h1f;
    localparam logic [7:0] MED_LEN_MIN   = 8'h30;
    localparam logic [7:0] MED_LEN_MAX   = 8'h33;
    localparam logic [7:0] FINAL_TAG     = 8'h53;  // 'S'
    localparam logic [7:0] MORE_TAG      = 8'h52;  // 'R'

    // utf-8 byte classes
    localparam logic [7:0] ASCII_MAX     = 8'h7f;
    localparam logic [7:0] LEAD2_MIN     = 8'hc2;
    localparam logic [7:0] LEAD2_MAX     = 8'hdf;
    localparam logic [7:0] LEAD3_MIN     = 8'he0;
    localparam logic [7:0] LEAD3_MAX     = 8'hef;
    localparam logic [7:0] LEAD4_MIN     = 8'hf0;
    localparam logic [7:0] LEAD4_MAX     = 8'hf4;
    localparam logic [7:0] CONT_MIN      = 8'h80;
    localparam logic [7:0] CONT_MAX      = 8'hbf;
    localparam logic [7:0] CONT3_LO_MIN  = 8'ha0;  // after e0: no overlong
    localparam logic [7:0] CONT3_HI_MAX  = 8'h9f;  // after ed: no surrogate
    localparam logic [7:0] CONT4_LO_MIN  = 8'h90;  // after f0: no overlong
    localparam logic [7:0] CONT4_HI_MAX  = 8'h8f;  // after f4: max 10ffff

    typedef struct packed {
        t_phase      phase;
        logic        final_chunk;
        logic        inside_string;
        logic [15:0] chars_left;
        logic [20:0] utf8_accum;
        logic [1:0]  utf8_bytes_left;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:           PH_PREFIX,
        final_chunk:     1'b0,
        inside_string:   1'b0,
        chars_left:      16'd0,
        utf8_accum:      21'd0,
        utf8_bytes_left: 2'd0
    };

    typedef struct packed {
        logic [20:0] code_point;
        logic        char_valid;
        logic        string_end;
        logic        error;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/u8d_if.sv -----
// stream channels of the deframer: raw bytes in, decoded results out
`default_nettype none

interface u8d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       stream_end;

    modport source (output valid, output in_byte, output stream_end, input ready);
    modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

interface u8d_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic        char_valid;
    logic        string_end;
    logic        error;

    modport source (output valid, output code_point, output char_valid,
                    output string_end, output error, input ready);
    modport sink   (input valid, input code_point, input char_valid,
                    input string_end, input error, output ready);
endinterface

`default_nettype wire

// ----- rtl/u8d_step.sv -----
// per-byte parser step: next state and optional result from state and one item
`default_nettype none

module u8d_step (
    input  wire u8d_pkg::t_state  i_state,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_stream_end,
    output u8d_pkg::t_state       o_state,
    output u8d_pkg::t_result      o_result,
    output logic                  o_result_vld
);

    u8d_pkg::t_state  n_st;
    u8d_pkg::t_result res;
    logic             has_res;
    logic             do_start;
    logic [15:0]      len;
    logic             do_char;
    logic             fail;
    logic [7:0]       lo;
    logic [7:0]       hi;
    logic [20:0]      cp;

    // phase decode
    always_comb begin
        n_st     = i_state;
        res      = '0;
        has_res  = 1'b0;
        do_start = 1'b0;
        len      = 16'd0;
        do_char  = 1'b0;
        fail     = 1'b0;
        lo       = u8d_pkg::CONT_MIN;
        hi       = u8d_pkg::CONT_MAX;
        cp       = 21'd0;

        if (i_stream_end) begin
            if (i_state.inside_string || i_state.phase != u8d_pkg::PH_PREFIX) begin
                fail = 1'b1;
            end else begin
                n_st = u8d_pkg::STATE_RESET;
            end
        end else begin
            case (i_state.phase)
                u8d_pkg::PH_PREFIX: begin
                    if (i_byte <= u8d_pkg::SHORT_LEN_MAX) begin
                        n_st.inside_string = 1'b1;
                        n_st.final_chunk   = 1'b1;
                        do_start           = 1'b1;
                        len                = {8'd0, i_byte};
                    end else if (i_byte inside {[u8d_pkg::MED_LEN_MIN:u8d_pkg::MED_LEN_MAX]})
                    begin
                        n_st.inside_string = 1'b1;
                        n_st.final_chunk   = 1'b1;
                        n_st.chars_left    = {6'd0, i_byte[1:0], 8'd0};
                        n_st.phase         = u8d_pkg::PH_LEN2;
                    end else if (i_byte == u8d_pkg::FINAL_TAG
                                 || i_byte == u8d_pkg::MORE_TAG) begin
                        n_st.inside_string = 1'b1;
                        n_st.final_chunk   = (i_byte == u8d_pkg::FINAL_TAG);
                        n_st.phase         = u8d_pkg::PH_WORDHI;
                    end else begin
                        fail = 1'b1;
                    end
                end
                u8d_pkg::PH_LEN2: begin
                    do_start = 1'b1;
                    len      = {i_state.chars_left[15:8], i_byte};
                end
                u8d_pkg::PH_WORDHI: begin
                    n_st.chars_left = {i_byte, 8'd0};
                    n_st.phase      = u8d_pkg::PH_WORDLO;
                end
                u8d_pkg::PH_WORDLO: begin
                    do_start = 1'b1;
                    len      = {i_state.chars_left[15:8], i_byte};
                end
                u8d_pkg::PH_LEAD: begin
                    n_st.phase = u8d_pkg::PH_CONT1;
                    if (i_byte <= u8d_pkg::ASCII_MAX) begin
                        n_st.utf8_accum = {13'd0, i_byte};
                        do_char         = 1'b1;
                    end else if (i_byte inside {[u8d_pkg::LEAD2_MIN:u8d_pkg::LEAD2_MAX]})
                    begin
                        n_st.utf8_accum      = {16'd0, i_byte[4:0]};
                        n_st.utf8_bytes_left = 2'd1;
                    end else if (i_byte inside {[u8d_pkg::LEAD3_MIN:u8d_pkg::LEAD3_MAX]})
                    begin
                        n_st.utf8_accum      = {17'd0, i_byte[3:0]};
                        n_st.utf8_bytes_left = 2'd2;
                    end else if (i_byte inside {[u8d_pkg::LEAD4_MIN:u8d_pkg::LEAD4_MAX]})
                    begin
                        n_st.utf8_accum      = {18'd0, i_byte[2:0]};
                        n_st.utf8_bytes_left = 2'd3;
                    end else begin
                        fail = 1'b1;
                    end
                end
                u8d_pkg::PH_CONT1, u8d_pkg::PH_CONTN: begin
                    // tightened second-byte ranges reject overlong, surrogate, too large
                    if (i_state.phase == u8d_pkg::PH_CONT1) begin
                        if (i_state.utf8_bytes_left == 2'd2) begin
                            if (i_state.utf8_accum == 21'd0)  lo = u8d_pkg::CONT3_LO_MIN;
                            if (i_state.utf8_accum == 21'hd)  hi = u8d_pkg::CONT3_HI_MAX;
                        end else if (i_state.utf8_bytes_left == 2'd3) begin
                            if (i_state.utf8_accum == 21'd0)  lo = u8d_pkg::CONT4_LO_MIN;
                            if (i_state.utf8_accum == 21'd4)  hi = u8d_pkg::CONT4_HI_MAX;
                        end
                    end
                    if (i_byte < lo || i_byte > hi) begin
                        fail = 1'b1;
                    end else begin
                        n_st.utf8_accum      = {i_state.utf8_accum[14:0], i_byte[5:0]};
                        n_st.utf8_bytes_left = i_state.utf8_bytes_left - 2'd1;
                        if (i_state.utf8_bytes_left == 2'd1) begin
                            do_char = 1'b1;
                        end else begin
                            n_st.phase = u8d_pkg::PH_CONTN;
                        end
                    end
                end
                default: begin
                    fail = 1'b1;
                end
            endcase
        end

        // chunk length complete
        if (do_start) begin
            n_st.chars_left = len;
            if (len != 16'd0) begin
                n_st.phase = u8d_pkg::PH_LEAD;
            end else if (n_st.final_chunk) begin
                n_st           = u8d_pkg::STATE_RESET;
                res.string_end = 1'b1;
                has_res        = 1'b1;
            end else begin
                n_st.phase = u8d_pkg::PH_PREFIX;
            end
        end

        // character complete
        if (do_char) begin
            cp                   = n_st.utf8_accum;
            n_st.utf8_accum      = 21'd0;
            n_st.utf8_bytes_left = 2'd0;
            n_st.chars_left      = i_state.chars_left - 16'd1;
            res.code_point       = cp;
            res.char_valid       = 1'b1;
            has_res              = 1'b1;
            if (n_st.chars_left != 16'd0) begin
                n_st.phase = u8d_pkg::PH_LEAD;
            end else if (n_st.final_chunk) begin
                n_st           = u8d_pkg::STATE_RESET;
                res.string_end = 1'b1;
            end else begin
                n_st.phase = u8d_pkg::PH_PREFIX;
            end
        end

        // malformed input: report and restart
        if (fail) begin
            n_st      = u8d_pkg::STATE_RESET;
            res       = '0;
            res.error = 1'b1;
            has_res   = 1'b1;
        end
    end

    assign o_state      = n_st;
    assign o_result     = res;
    assign o_result_vld = has_res;

endmodule

`default_nettype wire

// ----- rtl/chunked_utf8_string_deframer.sv -----
// top level of the chunked utf-8 string deframer
`default_nettype none

// Decodes a byte stream of length-prefixed utf-8 string chunks into code
// points, one byte item per cycle unless a result is held back. Each
// accepted byte lands in an input register; from there the parser state
// and that byte pass through one stage of decode logic into the parser
// state and the result register, which offers the result on the output.
// Bytes that close nothing (most prefix bytes, leading and middle utf-8 bytes)
// produce no result item. The input stays ready while the input register is
// empty or its byte moves on; a registered byte is held back only when it
// closes a result while the result register is full and not being drained.
// Errors (bad prefix, bad utf-8, stream closed inside a string) yield one
// result with error set and restart the parser.

module chunked_utf8_string_deframer (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    u8d_in_if.sink        i_in,
    u8d_out_if.source     o_out
);

    logic              r_in_vld;
    logic [7:0]        r_in_byte;
    logic              r_in_end;
    u8d_pkg::t_state   r_state;
    u8d_pkg::t_state   n_state;
    u8d_pkg::t_result  w_res;
    logic              w_res_vld;
    logic              r_out_vld;
    u8d_pkg::t_result  r_out;
    logic              w_adv;
    logic              w_out_free;

    // the registered byte moves on when its result, if any, has a free slot
    assign w_out_free = !r_out_vld || o_out.ready;
    assign w_adv      = r_in_vld && (!w_res_vld || w_out_free);
    assign i_in.ready = !r_in_vld || w_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
            r_in_end  <= i_in.stream_end;
        end
    end

    // decode logic
    u8d_step u_step (
        .i_state      (r_state),
        .i_byte       (r_in_byte),
        .i_stream_end (r_in_end),
        .o_state      (n_state),
        .o_result     (w_res),
        .o_result_vld (w_res_vld)
    );

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= u8d_pkg::STATE_RESET;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv && w_res_vld) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_res_vld) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.code_point = r_out.code_point;
    assign o_out.char_valid = r_out.char_valid;
    assign o_out.string_end = r_out.string_end;
    assign o_out.error      = r_out.error;

    // checks

    // an error result carries nothing else
    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.error) |-> (!r_out.char_valid && !r_out.string_end))
        else $error("error result carries character or string end");

    // any non-prefix phase lies inside a string
    a_phase_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase != u8d_pkg::PH_PREFIX) |-> r_state.inside_string)
        else $error("parser mid-string without inside flag");

    // an error or a completed string leaves the parser cleared
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_res_vld && (w_res.error || w_res.string_end))
        |=> (r_state.phase == u8d_pkg::PH_PREFIX && !r_state.inside_string
             && r_state.chars_left == 16'd0))
        else $error("parser not cleared after error or string end");

    // a result is never dropped while the output stalls
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_out.ready) |-> !(w_adv && w_res_vld))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

// ----- tb/tb_chunked_utf8_string_deframer.sv -----
// self-checking testbench of the chunked utf-8 string deframer
`default_nettype none

module tb_chunked_utf8_string_deframer;

    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 12;
    localparam int BYTES_PER_PHASE = 50;
    localparam int LONG_CHARS      = 257;
    localparam int LONG_STALL      = 300;
    localparam int DRAIN_CYCLES    = 10;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int NUM_PHASES      = 4;
    localparam int SEND_IDLE[NUM_PHASES]  = '{0, 75, 0, 35};
    localparam int RECV_STALL[NUM_PHASES] = '{0, 0, 75, 35};

    // expected results of the byte stream, computed byte by byte
    class decode_scoreboard;
        u8d_pkg::t_state  st;
        u8d_pkg::t_result expected_q[$];
        int      mismatches;
        int      bytes_seen;
        int      results_seen;
        int      chars_seen;
        int      strings_done;
        int      errors_seen;

        function new();
            st = u8d_pkg::STATE_RESET;
            mismatches = 0;
            bytes_seen = 0;
            results_seen = 0;
            chars_seen = 0;
            strings_done = 0;
            errors_seen = 0;
        endfunction

        function void emit(logic [20:0] cp, logic cv, logic se, logic er);
            u8d_pkg::t_result r;
            r.code_point = cp;
            r.char_valid = cv;
            r.string_end = se;
            r.error      = er;
            expected_q.push_back(r);
            chars_seen   += int'(cv);
            strings_done += int'(se);
            errors_seen  += int'(er);
        endfunction

        // malformed input: error item and parser restart
        function void abort_string();
            st = u8d_pkg::STATE_RESET;
            emit(21'd0, 1'b0, 1'b0, 1'b1);
        endfunction

        // chunk length fully read
        function void begin_chunk(logic [15:0] len);
            st.chars_left = len;
            if (len != 16'd0) begin
                st.phase = u8d_pkg::PH_LEAD;
            end else if (st.final_chunk) begin
                st = u8d_pkg::STATE_RESET;
                emit(21'd0, 1'b0, 1'b1, 1'b0);
            end else begin
                st.phase = u8d_pkg::PH_PREFIX;
            end
        endfunction

        // character fully decoded
        function void char_complete();
            logic [20:0] cp;
            cp = st.utf8_accum;
            st.utf8_accum = 21'd0;
            st.utf8_bytes_left = 2'd0;
            st.chars_left = st.chars_left - 16'd1;
            if (st.chars_left != 16'd0) begin
                st.phase = u8d_pkg::PH_LEAD;
                emit(cp, 1'b1, 1'b0, 1'b0);
            end else if (st.final_chunk) begin
                st = u8d_pkg::STATE_RESET;
                emit(cp, 1'b1, 1'b1, 1'b0);
            end else begin
                st.phase = u8d_pkg::PH_PREFIX;
                emit(cp, 1'b1, 1'b0, 1'b0);
            end
        endfunction

        function void note_byte(logic [7:0] b, logic close);
            logic [7:0] lo;
            logic [7:0] hi;
            bytes_seen++;
            // stream closed: error only when a string is open
            if (close) begin
                if (st.inside_string || st.phase != u8d_pkg::PH_PREFIX) begin
                    abort_string();
                end else begin
                    st = u8d_pkg::STATE_RESET;
                end
                return;
            end
            case (st.phase)
                u8d_pkg::PH_PREFIX: begin
                    if (b <= u8d_pkg::SHORT_LEN_MAX) begin
                        st.inside_string = 1'b1;
                        st.final_chunk = 1'b1;
                        begin_chunk({8'd0, b});
                    end else if (b >= u8d_pkg::MED_LEN_MIN && b <= u8d_pkg::MED_LEN_MAX) begin
                        st.inside_string = 1'b1;
                        st.final_chunk = 1'b1;
                        st.chars_left = {6'd0, b[1:0], 8'd0};
                        st.phase = u8d_pkg::PH_LEN2;
                    end else if (b == u8d_pkg::FINAL_TAG || b == u8d_pkg::MORE_TAG) begin
                        st.inside_string = 1'b1;
                        st.final_chunk = (b == u8d_pkg::FINAL_TAG);
                        st.phase = u8d_pkg::PH_WORDHI;
                    end else begin
                        abort_string();
                    end
                end
                u8d_pkg::PH_LEN2: begin_chunk(st.chars_left + {8'd0, b});
                u8d_pkg::PH_WORDHI: begin
                    st.chars_left = {b, 8'd0};
                    st.phase = u8d_pkg::PH_WORDLO;
                end
                u8d_pkg::PH_WORDLO: begin_chunk(st.chars_left | {8'd0, b});
                u8d_pkg::PH_LEAD: begin
                    if (b <= u8d_pkg::ASCII_MAX) begin
                        st.utf8_accum = {13'd0, b};
                        char_complete();
                    end else if (b >= u8d_pkg::LEAD2_MIN && b <= u8d_pkg::LEAD2_MAX) begin
                        st.utf8_accum = {16'd0, b[4:0]};
                        st.utf8_bytes_left = 2'd1;
                        st.phase = u8d_pkg::PH_CONT1;
                    end else if (b >= u8d_pkg::LEAD3_MIN && b <= u8d_pkg::LEAD3_MAX) begin
                        st.utf8_accum = {17'd0, b[3:0]};
                        st.utf8_bytes_left = 2'd2;
                        st.phase = u8d_pkg::PH_CONT1;
                    end else if (b >= u8d_pkg::LEAD4_MIN && b <= u8d_pkg::LEAD4_MAX) begin
                        st.utf8_accum = {18'd0, b[2:0]};
                        st.utf8_bytes_left = 2'd3;
                        st.phase = u8d_pkg::PH_CONT1;
                    end else begin
                        abort_string();
                    end
                end
                u8d_pkg::PH_CONT1, u8d_pkg::PH_CONTN: begin
                    lo = u8d_pkg::CONT_MIN;
                    hi = u8d_pkg::CONT_MAX;
                    // tighter range on the second byte: overlong, surrogate, above max
                    if (st.phase == u8d_pkg::PH_CONT1) begin
                        if (st.utf8_bytes_left == 2'd2) begin
                            if (st.utf8_accum == 21'd0) lo = u8d_pkg::CONT3_LO_MIN;
                            if (st.utf8_accum == 21'hd) hi = u8d_pkg::CONT3_HI_MAX;
                        end else if (st.utf8_bytes_left == 2'd3) begin
                            if (st.utf8_accum == 21'd0) lo = u8d_pkg::CONT4_LO_MIN;
                            if (st.utf8_accum == 21'd4) hi = u8d_pkg::CONT4_HI_MAX;
                        end
                    end
                    if (b < lo || b > hi) begin
                        abort_string();
                    end else begin
                        st.utf8_accum = {st.utf8_accum[14:0], b[5:0]};
                        st.utf8_bytes_left = st.utf8_bytes_left - 2'd1;
                        if (st.utf8_bytes_left == 2'd0) begin
                            char_complete();
                        end else begin
                            st.phase = u8d_pkg::PH_CONTN;
                        end
                    end
                end
                default: abort_string();
            endcase
        endfunction

        function void check_result(u8d_pkg::t_result got);
            u8d_pkg::t_result want;
            results_seen++;
            if (expected_q.size() == 0) begin
                $error("unexpected result item: code_point %0h char_valid %0b %s %0b %s %0b",
                       got.code_point, got.char_valid, "string_end", got.string_end,
                       "error", got.error);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (got.code_point !== want.code_point) begin
                $error("code_point expected %0h actual %0h", want.code_point, got.code_point);
                mismatches++;
            end
            if (got.char_valid !== want.char_valid) begin
                $error("char_valid expected %0b actual %0b", want.char_valid, got.char_valid);
                mismatches++;
            end
            if (got.string_end !== want.string_end) begin
                $error("string_end expected %0b actual %0b", want.string_end, got.string_end);
                mismatches++;
            end
            if (got.error !== want.error) begin
                $error("error expected %0b actual %0b", want.error, got.error);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    u8d_in_if  in_ch ();
    u8d_out_if out_ch ();

    chunked_utf8_string_deframer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    decode_scoreboard sb = new();

    // bit 8 set: stream close marker
    logic [8:0] byte_plan[$];
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         stall_kicks    = 0;
    int         cycle_count    = 0;

    // clock
    always #HALF_PERIOD i_clk = ~i_clk;

    // run time limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic void plan_byte(logic [7:0] b);
        byte_plan.push_back({1'b0, b});
    endfunction

    function automatic void plan_close();
        byte_plan.push_back({1'b1, 8'($urandom)});
    endfunction

    // one random scalar value, utf-8 encoded
    function automatic void plan_char();
        logic [20:0] cp;
        int          kind;
        logic [20:0] edges[10] = '{21'h0, 21'h7f, 21'h80, 21'h7ff, 21'h800,
                                   21'hd7ff, 21'he000, 21'hffff, 21'h10000, 21'h10ffff};
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            cp = edges[$urandom_range(0, 9)];
        end else if (kind < 55) begin
            cp = 21'($urandom_range(0, 'h7f));
        end else if (kind < 70) begin
            cp = 21'($urandom_range('h80, 'h7ff));
        end else if (kind < 85) begin
            do cp = 21'($urandom_range('h800, 'hffff));
            while (cp >= 21'hd800 && cp <= 21'hdfff);
        end else begin
            cp = 21'($urandom_range('h10000, 'h10ffff));
        end
        if (cp < 21'h80) begin
            plan_byte(cp[7:0]);
        end else if (cp < 21'h800) begin
            plan_byte({3'b110, cp[10:6]});
            plan_byte({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            plan_byte({4'b1110, cp[15:12]});
            plan_byte({2'b10, cp[11:6]});
            plan_byte({2'b10, cp[5:0]});
        end else begin
            plan_byte({5'b11110, cp[20:18]});
            plan_byte({2'b10, cp[17:12]});
            plan_byte({2'b10, cp[11:6]});
            plan_byte({2'b10, cp[5:0]});
        end
    endfunction

    // length prefix in a random legal form, then the characters
    function automatic void plan_chunk(bit last, int n);
        logic [15:0] len;
        int          form;
        len = 16'(n);
        form = $urandom_range(0, 2);
        if (!last) begin
            plan_byte(u8d_pkg::MORE_TAG);
            plan_byte(len[15:8]);
            plan_byte(len[7:0]);
        end else if (form == 0 && n <= 31) begin
            plan_byte(len[7:0]);
        end else if (form <= 1 && n <= 1023) begin
            plan_byte(u8d_pkg::MED_LEN_MIN | {6'd0, len[9:8]});
            plan_byte(len[7:0]);
        end else begin
            plan_byte(u8d_pkg::FINAL_TAG);
            plan_byte(len[15:8]);
            plan_byte(len[7:0]);
        end
        repeat (n) plan_char();
    endfunction

    // a whole string, sometimes corrupted or cut short
    function automatic void plan_string();
        int start;
        int pick;
        int n;
        start = byte_plan.size();
        repeat ($urandom_range(0, 2)) plan_chunk(1'b0, $urandom_range(0, 4));
        pick = $urandom_range(0, 99);
        if (pick < 85) n = $urandom_range(0, 6);
        else           n = $urandom_range(7, 40);
        plan_chunk(1'b1, n);
        pick = $urandom_range(0, 99);
        if (pick >= 75 && pick < 87) begin
            byte_plan[start + $urandom_range(0, byte_plan.size() - start - 1)] =
                {1'b0, 8'($urandom)};
            plan_close();
        end else if (pick >= 87) begin
            n = $urandom_range(0, byte_plan.size() - start - 1);
            while (byte_plan.size() > start + n) void'(byte_plan.pop_back());
            plan_close();
        end
    endfunction

    // offer one item, with a random gap first
    task automatic drive_byte(logic [8:0] item);
        int gap;
        gap = 0;
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.in_byte    <= item[7:0];
        in_ch.stream_end <= item[8];
        do @(posedge i_clk);
        while (!in_ch.ready);
        sb.note_byte(item[7:0], item[8]);
    endtask

    task automatic send_plan();
        while (byte_plan.size() > 0) drive_byte(byte_plan.pop_front());
    endtask

    // result side: check accepted items, drive ready
    initial begin : result_sink
        u8d_pkg::t_result got;
        int      stall_left;
        int      kicks_seen;
        stall_left = 0;
        kicks_seen = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                got.code_point = out_ch.code_point;
                got.char_valid = out_ch.char_valid;
                got.string_end = out_ch.string_end;
                got.error      = out_ch.error;
                sb.check_result(got);
            end
            if (stall_kicks != kicks_seen) begin
                kicks_seen = stall_kicks;
                stall_left = LONG_STALL;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // stimulus
    initial begin : byte_source
        int phase_start;
        int pick;
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.in_byte    <= 8'd0;
        in_ch.stream_end <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty final chunk, idle close, bad prefix
        plan_byte(8'h00);
        plan_close();
        plan_byte(8'h20);
        // empty non-final chunk, then nul character ending the string
        plan_byte(u8d_pkg::MORE_TAG); plan_byte(8'h00); plan_byte(8'h00);
        plan_byte(8'h01); plan_byte(8'h00);
        // empty final chunk in medium form
        plan_byte(u8d_pkg::MED_LEN_MIN); plan_byte(8'h00);
        // largest length, top scalar value, then close inside the string
        plan_byte(u8d_pkg::FINAL_TAG); plan_byte(8'hff); plan_byte(8'hff);
        plan_byte(8'hf4); plan_byte(8'h8f); plan_byte(8'hbf); plan_byte(8'hbf);
        plan_close();
        // overlong three-byte form
        plan_byte(u8d_pkg::MED_LEN_MAX); plan_byte(8'hff);
        plan_byte(8'he0); plan_byte(8'h9f);
        // surrogate
        plan_byte(8'h01); plan_byte(8'hed); plan_byte(8'ha0);
        // above the largest scalar value
        plan_byte(8'h01); plan_byte(8'hf4); plan_byte(8'h90);
        // overlong two-byte lead
        plan_byte(8'h01); plan_byte(8'hc1);
        // long final chunk in medium form, length above one byte
        plan_byte(u8d_pkg::MED_LEN_MIN | 8'h01); plan_byte(8'h01);
        repeat (LONG_CHARS) plan_byte(8'($urandom_range(0, 'h7f)));
        send_plan();

        // random strings under each idling pattern
        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct  = SEND_IDLE[p];
            recv_stall_pct = RECV_STALL[p];
            // long receiver hold-off while the sender keeps offering
            if (p == 0) stall_kicks++;
            phase_start = sb.bytes_seen;
            while (sb.bytes_seen - phase_start < BYTES_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 80) begin
                    plan_string();
                end else if (pick < 92) begin
                    repeat ($urandom_range(1, 4)) plan_byte(8'($urandom));
                    plan_close();
                end else begin
                    plan_close();
                end
                send_plan();
            end
        end
        in_ch.valid <= 1'b0;

        // drain
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d bytes sent, %0d result items checked:", sb.bytes_seen,
                 sb.results_seen);
        $display("  %0d characters, %0d strings, %0d errors; idle, sender gaps,",
                 sb.chars_seen, sb.strings_done, sb.errors_seen);
        $display("  receiver stalls and both, with one long receiver hold-off");
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/u8d_pkg.sv
rtl/u8d_if.sv
rtl/u8d_step.sv
rtl/chunked_utf8_string_deframer.sv
tb/tb_chunked_utf8_string_deframer.sv
